// ===== hdl/tbr_pkg.sv =====
// Shared types and constants for the triangle bounding-box rasterizer.
// Holds the command and pixel transaction structs and the register map.
// No dependencies.
package tbr_pkg;

  // Vertex coordinate width and derived arithmetic widths.
  localparam int COORD_BITS = 12;
  localparam int DIFF_W     = COORD_BITS + 1;   // signed coordinate difference
  localparam int PROD_W     = 2 * DIFF_W;       // signed product of two differences
  localparam int WGT_W      = PROD_W + 1;       // signed edge weight or doubled area
  localparam int CMP_W      = WGT_W + 1;        // weight sum and bound compares

  // Configuration registers.
  localparam int REG_BITS   = 13;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;
  localparam logic [REG_BITS-1:0] SCREEN_WIDTH_RESET  = REG_BITS'(640);
  localparam logic [REG_BITS-1:0] SCREEN_HEIGHT_RESET = REG_BITS'(480);

  // Register index, taken from the word address bit.
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Command codes.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Fixed output field widths.
  localparam int ROW_BITS   = 12;
  localparam int OFFSET_W   = 26;
  localparam int COLOR_BITS = 32;

  typedef struct packed {
    logic                  action;
    logic [COORD_BITS-1:0] vertex0_x;
    logic [COORD_BITS-1:0] vertex0_y;
    logic [COORD_BITS-1:0] vertex1_x;
    logic [COORD_BITS-1:0] vertex1_y;
    logic [COORD_BITS-1:0] vertex2_x;
    logic [COORD_BITS-1:0] vertex2_y;
    logic [COLOR_BITS-1:0] fill_color;
  } cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [ROW_BITS-1:0]   pixel_row;
    logic [OFFSET_W-1:0]   pixel_offset;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  covered;
    logic                  done_res;
  } pix_t;

endpackage

// ===== hdl/triangle_bbox_rasterizer.sv =====
// Triangle bounding-box rasterizer: one pixel test per tick command.
// Depends on tbr_pkg for the command and pixel structs and the register map.
//
// Usage:
//   cmd channel (cmd_valid, cmd_stall, cmd): a start command loads three
//   vertices and a color and places the cursor at the top-left of the
//   bounding box; each tick command tests the pixel under the cursor and
//   steps the cursor in row-major order. Start commands and ticks while
//   idle produce no pixel transaction.
//   pix channel (pix_valid, pix_stall, pix): one transaction per busy tick,
//   carrying column, flipped row, byte offset, color, coverage and a done
//   flag on the last pixel of the box.
//   APB port: screen_width at byte address 0, screen_height at address 4;
//   write them only while no scan is in flight.
// Timing: an accepted tick loads the middle stage (cursor offsets, clip,
// flipped row); its pixel then moves into the result register once that
// register is free. One command is accepted every cycle while cmd_stall is low.
// Reset clears the scan state and loads a 640 by 480 screen.
// When the receiver stalls, the result register holds, the middle stage
// fills, and cmd_stall rises until the result is taken.
module triangle_bbox_rasterizer
  import tbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Command channel.
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_t                 cmd,
  // Pixel channel.
  output logic                 pix_valid,
  input  logic                 pix_stall,
  output pix_t                 pix,
  // APB configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  // Configuration registers.
  logic [REG_BITS-1:0] screen_width;
  logic [REG_BITS-1:0] screen_height;

  // Triangle state loaded on start.
  logic                     busy;
  logic [COORD_BITS-1:0]    x0, y0;
  logic signed [DIFF_W-1:0] ex, ey, fx, fy;
  logic signed [WGT_W-1:0]  doubled_area;
  logic [COLOR_BITS-1:0]    color_store;
  logic [COORD_BITS-1:0]    box_min_x, box_max_x, box_max_y;
  logic [COORD_BITS-1:0]    cursor_x, cursor_y;

  // Middle stage.
  logic                     s1_valid;
  logic [COORD_BITS-1:0]    s1_x;
  logic signed [DIFF_W-1:0] s1_gx, s1_gy, s1_ex, s1_ey, s1_fx, s1_fy;
  logic signed [WGT_W-1:0]  s1_area;
  logic [COLOR_BITS-1:0]    s1_color;
  logic [REG_BITS-1:0]      s1_row;
  logic                     s1_on_screen;
  logic                     s1_last;

  // Handshake and control.
  logic cmd_fire, tick_fire, start_fire, out_adv, s1_valid_next, out_valid_next;
  logic cfg_write;

  // Start-path arithmetic.
  logic signed [DIFF_W-1:0] st_ex, st_ey, st_fx, st_fy;
  logic signed [PROD_W-1:0] st_p1, st_p2;
  logic [COORD_BITS-1:0]    st_min_x, st_max_x, st_min_y, st_max_y, m01;

  // Tick-path first stage.
  logic                     on_screen, last;
  logic [REG_BITS-1:0]      row;

  // Second stage arithmetic.
  logic signed [PROD_W-1:0] p_fg, p_gf, p_ge, p_eg;
  logic signed [CMP_W-1:0]  wu, wv, wsum, area_c, lo, hi;
  logic                     hit;
  logic [2*REG_BITS-1:0]    row_mul;
  logic [OFFSET_W-3:0]      off_word;
  pix_t                     pix_next;

  // APB access: always ready, register chosen by the word address bit.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_SCREEN_WIDTH:  prdata = DATA_BITS'(screen_width);
      REG_SCREEN_HEIGHT: prdata = DATA_BITS'(screen_height);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SCREEN_WIDTH) begin
        screen_width <= pwdata[REG_BITS-1:0];
      end else begin
        screen_height <= pwdata[REG_BITS-1:0];
      end
    end
  end

  // Flow control: the result register frees a slot, the middle stage follows.
  assign out_adv    = !pix_valid || !pix_stall;
  assign cmd_stall  = s1_valid && !out_adv;
  assign cmd_fire   = cmd_valid && !cmd_stall;
  assign start_fire = cmd_fire && (cmd.action == ACT_START);
  assign tick_fire  = cmd_fire && (cmd.action == ACT_TICK) && busy;

  assign s1_valid_next  = (s1_valid && !out_adv) || tick_fire;
  assign out_valid_next = (s1_valid && out_adv) || (pix_valid && pix_stall);

  // Start: edge vectors, doubled signed area and bounding box.
  always_comb begin
    st_ex = $signed({1'b0, cmd.vertex2_x}) - $signed({1'b0, cmd.vertex0_x});
    st_ey = $signed({1'b0, cmd.vertex2_y}) - $signed({1'b0, cmd.vertex0_y});
    st_fx = $signed({1'b0, cmd.vertex1_x}) - $signed({1'b0, cmd.vertex0_x});
    st_fy = $signed({1'b0, cmd.vertex1_y}) - $signed({1'b0, cmd.vertex0_y});
    st_p1 = st_ex * st_fy;
    st_p2 = st_fx * st_ey;

    m01      = (cmd.vertex0_x < cmd.vertex1_x) ? cmd.vertex0_x : cmd.vertex1_x;
    st_min_x = (m01 < cmd.vertex2_x) ? m01 : cmd.vertex2_x;
    m01      = (cmd.vertex0_x > cmd.vertex1_x) ? cmd.vertex0_x : cmd.vertex1_x;
    st_max_x = (m01 > cmd.vertex2_x) ? m01 : cmd.vertex2_x;
    m01      = (cmd.vertex0_y < cmd.vertex1_y) ? cmd.vertex0_y : cmd.vertex1_y;
    st_min_y = (m01 < cmd.vertex2_y) ? m01 : cmd.vertex2_y;
    m01      = (cmd.vertex0_y > cmd.vertex1_y) ? cmd.vertex0_y : cmd.vertex1_y;
    st_max_y = (m01 > cmd.vertex2_y) ? m01 : cmd.vertex2_y;
  end

  // Tick: clip, flipped row and end-of-box detection for the cursor pixel.
  always_comb begin
    on_screen = (REG_BITS'(cursor_x) < screen_width) &&
                (REG_BITS'(cursor_y) < screen_height);
    row       = screen_height - REG_BITS'(1) - REG_BITS'(cursor_y);
    last      = (cursor_x == box_max_x) && (cursor_y == box_max_y);
  end

  // Scan state: loaded by a start, stepped by each busy tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      x0           <= '0;
      y0           <= '0;
      ex           <= '0;
      ey           <= '0;
      fx           <= '0;
      fy           <= '0;
      doubled_area <= '0;
      color_store  <= '0;
      box_min_x    <= '0;
      box_max_x    <= '0;
      box_max_y    <= '0;
      cursor_x     <= '0;
      cursor_y     <= '0;
    end else if (start_fire) begin
      busy         <= 1'b1;
      x0           <= cmd.vertex0_x;
      y0           <= cmd.vertex0_y;
      ex           <= st_ex;
      ey           <= st_ey;
      fx           <= st_fx;
      fy           <= st_fy;
      doubled_area <= WGT_W'(st_p1) - WGT_W'(st_p2);
      color_store  <= cmd.fill_color;
      box_min_x    <= st_min_x;
      box_max_x    <= st_max_x;
      box_max_y    <= st_max_y;
      cursor_x     <= st_min_x;
      cursor_y     <= st_min_y;
    end else if (tick_fire) begin
      if (last) begin
        busy <= 1'b0;
      end else if (cursor_x == box_max_x) begin
        cursor_x <= box_min_x;
        cursor_y <= cursor_y + COORD_BITS'(1);
      end else begin
        cursor_x <= cursor_x + COORD_BITS'(1);
      end
    end
  end

  // Middle stage: snapshot of the triangle so a following start cannot disturb it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      s1_x         <= cursor_x;
      s1_gx        <= $signed({1'b0, x0}) - $signed({1'b0, cursor_x});
      s1_gy        <= $signed({1'b0, y0}) - $signed({1'b0, cursor_y});
      s1_ex        <= ex;
      s1_ey        <= ey;
      s1_fx        <= fx;
      s1_fy        <= fy;
      s1_area      <= doubled_area;
      s1_color     <= color_store;
      s1_row       <= row;
      s1_on_screen <= on_screen;
      s1_last      <= last;
    end
  end

  // Second stage: edge products, inclusive bound checks and byte offset.
  always_comb begin
    p_fg   = s1_fx * s1_gy;
    p_gf   = s1_gx * s1_fy;
    p_ge   = s1_gx * s1_ey;
    p_eg   = s1_ex * s1_gy;
    wu     = CMP_W'(p_fg) - CMP_W'(p_gf);
    wv     = CMP_W'(p_ge) - CMP_W'(p_eg);
    wsum   = wu + wv;
    area_c = CMP_W'(s1_area);
    // Bounds follow the sign of the area.
    if (area_c > 0) begin
      lo = '0;
      hi = area_c;
    end else begin
      lo = area_c;
      hi = '0;
    end
    hit = s1_on_screen && (area_c != 0) &&
          (wu >= lo) && (wu <= hi) &&
          (wv >= lo) && (wv <= hi) &&
          (wsum >= lo) && (wsum <= hi);

    row_mul  = s1_row * screen_width;
    off_word = row_mul[OFFSET_W-3:0] + (OFFSET_W-2)'(s1_x);

    pix_next.pixel_x      = s1_x;
    pix_next.pixel_row    = s1_on_screen ? s1_row[ROW_BITS-1:0] : '0;
    pix_next.pixel_offset = s1_on_screen ? {off_word, 2'b00} : '0;
    pix_next.pixel_color  = hit ? s1_color : '0;
    pix_next.covered      = hit;
    pix_next.done_res     = s1_last;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      pix_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_adv) begin
      pix <= pix_next;
    end
  end

endmodule
